// ===== rtl/core/dhss_pkg.sv =====
// Shared types and constants for the hairpin stem scanner.
package dhss_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam int SPAN_W = 7;
  localparam int STRENGTH_W = 8;
  localparam logic [SPAN_W-1:0] LOOP_SPAN_RESET = 7'd5;

  // Two 2-bit base codes pair exactly when they sum to this value.
  localparam logic [2:0] PAIR_SUM = 3'd3;

  typedef struct packed {
    logic [1:0] nucleotide;
    logic       is_last;
  } dhss_in_t;

  typedef struct packed {
    logic [STRENGTH_W-1:0] stem_strength;
    logic                  overflowed;
  } dhss_out_t;

endpackage

// ===== rtl/core/dhss_store.sv =====
// Sequence memory: one write port, two registered read ports.
module dhss_store import dhss_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(MAX_LEN)-1:0] waddr,
  input  logic [1:0]                 wdata,
  input  logic [$clog2(MAX_LEN)-1:0] raddr_a,
  input  logic [$clog2(MAX_LEN)-1:0] raddr_b,
  output logic [1:0]                 rdata_a,
  output logic [1:0]                 rdata_b
);

  logic [1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/dhss_scan.sv =====
// Load sequencer and stem scan loop around a single pair comparator.
module dhss_scan import dhss_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dhss_in_t                   in_data,
  input  logic [SPAN_W-1:0]          loop_span,
  output logic                       res_valid,
  input  logic                       res_ready,
  output dhss_out_t                  res_data,
  output logic                       mem_we,
  output logic [$clog2(MAX_LEN)-1:0] mem_waddr,
  output logic [1:0]                 mem_wdata,
  output logic [$clog2(MAX_LEN)-1:0] mem_raddr_a,
  output logic [$clog2(MAX_LEN)-1:0] mem_raddr_b,
  input  logic [1:0]                 mem_rdata_a,
  input  logic [1:0]                 mem_rdata_b
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int RW = $clog2(MAX_LEN + (1 << SPAN_W));
  localparam int CW = (LW > STRENGTH_W) ? LW : STRENGTH_W + 1;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_PROBE = 5'b00010,
    S_READ  = 5'b00100,
    S_CMP   = 5'b01000,
    S_OUT   = 5'b10000
  } scan_state_t;

  scan_state_t   state;
  logic [LW-1:0] len;
  logic          ovf;
  logic [LW-1:0] p;
  logic [AW:0]   l;
  logic [RW-1:0] r;
  logic [CW-1:0] n;
  logic [CW-1:0] best;

  logic accept;
  logic full;
  logic hit;
  logic pair;
  logic n_gt_best;

  assign in_stall  = (state != S_LOAD);
  assign accept    = in_valid && (state == S_LOAD);
  assign full      = (len == LW'(MAX_LEN));

  assign mem_we    = accept && !full;
  assign mem_waddr = len[AW-1:0];
  assign mem_wdata = in_data.nucleotide;

  // left index still in range and right index below the length
  assign hit         = !l[AW] && (r < RW'(len));
  assign mem_raddr_a = l[AW-1:0];
  assign mem_raddr_b = r[AW-1:0];

  assign pair      = (({1'b0, mem_rdata_a} + {1'b0, mem_rdata_b}) == PAIR_SUM);
  assign n_gt_best = (n > best);

  assign res_valid = (state == S_OUT);
  assign res_data.stem_strength = (best > CW'(255)) ? 8'hFF : best[STRENGTH_W-1:0];
  assign res_data.overflowed    = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      len   <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              len <= len + 1'b1;
            end
            if (in_data.is_last) begin
              state <= S_PROBE;
              p     <= '0;
              best  <= '0;
            end
          end
        end
        S_PROBE: begin
          if (p >= len) begin
            state <= S_OUT;
          end else begin
            l     <= {1'b0, p[AW-1:0]};
            r     <= RW'(p) + RW'(loop_span);
            n     <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (hit) begin
            state <= S_CMP;
          end else begin
            if (n_gt_best) begin
              best <= n;
            end
            p     <= p + 1'b1;
            state <= S_PROBE;
          end
        end
        S_CMP: begin
          if (pair) begin
            n     <= n + 1'b1;
            l     <= l - 1'b1;
            r     <= r + 1'b1;
            state <= S_READ;
          end else begin
            if (n_gt_best) begin
              best <= n;
            end
            p     <= p + 1'b1;
            state <= S_PROBE;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            len   <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dna_hairpin_stem_scan.sv =====
// Top level of the hairpin stem scanner: span register, sequence memory, scan core, result register.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------
//   input     | in_valid / in_stall  | in_data  (nucleotide, is_last)
//   output    | out_valid / out_stall| out_data (stem_strength, overflowed)
//   config    | cfg_write            | cfg_data (loop_span)
//
// Loading takes one nucleotide per cycle. On the last one the scan runs:
// per left stem end a probe step and a read step, a compare step and a
// further read step per matched pair and a compare step when a mismatch
// ends the run, then a closing probe step and the output state, held until
// the result is handed over. The pace is set by the one comparator and
// the registered memory read. in_stall is high from the last nucleotide until
// the result moves into the output register; a stalled result holds there
// while the next sequence loads. Synchronous reset clears control state only.
module dna_hairpin_stem_scan import dhss_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dhss_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dhss_out_t         out_data,
  input  logic              cfg_write,
  input  logic [SPAN_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LEN);

  logic [SPAN_W-1:0] loop_span;
  logic              res_valid;
  logic              res_ready;
  dhss_out_t         res_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [1:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr_a;
  logic [AW-1:0]     mem_raddr_b;
  logic [1:0]        mem_rdata_a;
  logic [1:0]        mem_rdata_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_span <= LOOP_SPAN_RESET;
    end else if (cfg_write) begin
      loop_span <= cfg_data;
    end
  end

  dhss_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  dhss_scan #(.MAX_LEN(MAX_LEN)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .loop_span   (loop_span),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  // take a result whenever the output register is empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid)
    else $error("result transaction did not reach the output register");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.is_last |=> in_stall)
    else $error("input accepted while a scan should be running");

  a_strength_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 32'(res_data.stem_strength) <= MAX_LEN / 2)
    else $error("stem strength beyond half the capacity");

endmodule
